// ===== src/tama_pkg.sv =====
`default_nettype none

package tama_pkg;

  // width of one axis reading and of one axis mean
  localparam int unsigned SAMPLE_W = 16;

  // running sum width, holds any window of up to 16 readings exactly
  localparam int unsigned SUM_W = 20;

  // magnitude of a running sum, at most 2^19
  localparam int unsigned MAG_W = SUM_W;

  // reciprocal scaling for the constant divide
  localparam int unsigned DIV_SHIFT = 25;
  localparam int unsigned RECIP_W   = 25;
  localparam int unsigned PROD_W    = MAG_W + RECIP_W;

  // number of axes carried by one beat
  localparam int unsigned AXES = 3;

  // packed beat width, three fields rounded up to whole bytes
  localparam int unsigned DATA_W = ((AXES * SAMPLE_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== src/tama_lane.sv =====
`default_nettype none

module tama_lane #(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 load,
  input  wire logic [$clog2(WINDOW)-1:0]            slot,
  input  wire logic signed [tama_pkg::SAMPLE_W-1:0] sample,
  output logic signed [tama_pkg::SUM_W-1:0]         sum
);

  localparam int unsigned EXT_W = tama_pkg::SUM_W - tama_pkg::SAMPLE_W;

  logic signed [tama_pkg::SAMPLE_W-1:0] ring [WINDOW];
  logic signed [tama_pkg::SAMPLE_W-1:0] oldest;
  logic signed [tama_pkg::SUM_W-1:0]    oldest_ext;
  logic signed [tama_pkg::SUM_W-1:0]    sample_ext;
  logic signed [tama_pkg::SUM_W-1:0]    sum_next;

  assign oldest     = ring[slot];
  assign oldest_ext = {{EXT_W{oldest[tama_pkg::SAMPLE_W-1]}}, oldest};
  assign sample_ext = {{EXT_W{sample[tama_pkg::SAMPLE_W-1]}}, sample};
  assign sum_next   = sum - oldest_ext + sample_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
      sum <= '0;
    end else if (load) begin
      ring[slot] <= sample;
      sum        <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/tama_div.sv =====
`default_nettype none

module tama_div #(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [tama_pkg::SUM_W-1:0]    sum,
  output logic signed [tama_pkg::SAMPLE_W-1:0]      mean
);

  // ceil(2^shift / window), exact for every sum magnitude up to 2^19
  localparam logic [tama_pkg::RECIP_W-1:0] RECIP =
    tama_pkg::RECIP_W'(((64'd1 << tama_pkg::DIV_SHIFT) + WINDOW - 1) / WINDOW);

  logic [tama_pkg::MAG_W-1:0]  mag;
  logic [tama_pkg::PROD_W-1:0] prod;
  logic                        neg;
  logic [tama_pkg::SAMPLE_W-1:0] quot;

  assign mag = sum[tama_pkg::SUM_W-1] ? tama_pkg::MAG_W'(-sum) : tama_pkg::MAG_W'(sum);

  always_ff @(posedge clk) begin
    if (en) begin
      neg  <= sum[tama_pkg::SUM_W-1];
      prod <= tama_pkg::PROD_W'(mag) * tama_pkg::PROD_W'(RECIP);
    end
  end

  // truncation toward zero: divide the magnitude, then restore the sign
  assign quot = prod[tama_pkg::DIV_SHIFT +: tama_pkg::SAMPLE_W];
  assign mean = neg ? -quot : quot;

endmodule

`default_nettype wire

// ===== src/three_axis_moving_average_top.sv =====
`default_nettype none

// three-axis moving average over the last WINDOW readings of each axis
// input beat (s_*): one signed 16-bit reading per axis, x in the low bits
// output beat (m_*): one signed 16-bit mean per axis, same packing
// every accepted input beat yields exactly one output beat, in order
// steps from an accepted beat to m_tvalid, in order:
//   the accepting edge updates the ring and running sum of each lane
//   then the reciprocal product of each sum magnitude is registered
//   last, the sign is restored and the output register is loaded
// throughput: one beat per cycle while m_tready does not stall the pipe
// the three lanes run side by side; the output register merges them
// a stall on m_tready freezes the whole pipe and drops s_tready, so
// nothing is lost; with the output register empty or draining, a new
// beat is taken every cycle
// reset clears the rings, the sums, the write slot and all valid flags;
// the first WINDOW-1 means average the new readings against zeros
module three_axis_moving_average_top #(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [tama_pkg::DATA_W-1:0] s_tdata,  // sample_x, sample_y, sample_z
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [tama_pkg::DATA_W-1:0]      m_tdata   // mean_x, mean_y, mean_z
);

  localparam int unsigned PTR_W = $clog2(WINDOW);
  localparam int unsigned SW    = tama_pkg::SAMPLE_W;

  logic             advance;
  logic             accept;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_next;
  logic             sum_vld;   // lane sums hold a fresh beat
  logic             prod_vld;  // divider products hold a fresh beat

  logic signed [tama_pkg::SUM_W-1:0] lane_sum  [tama_pkg::AXES];
  logic signed [SW-1:0]              lane_mean [tama_pkg::AXES];

  // the pipe moves whenever the output register is free or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && advance;

  // ring write slot shared by all lanes, wraps at the window length
  assign ptr_next = (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + PTR_W'(1);

  for (genvar a = 0; a < tama_pkg::AXES; a++) begin : g_lane
    tama_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .load   (accept),
      .slot   (ptr),
      .sample (s_tdata[a*SW +: SW]),
      .sum    (lane_sum[a])
    );

    tama_div #(
      .WINDOW (WINDOW)
    ) u_div (
      .clk  (clk),
      .en   (advance),
      .sum  (lane_sum[a]),
      .mean (lane_mean[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      sum_vld  <= 1'b0;
      prod_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        ptr <= ptr_next;
      end
      if (advance) begin
        sum_vld  <= accept;
        prod_vld <= sum_vld;
        m_tvalid <= prod_vld;
      end
    end
  end

  // merge the three lane means into one output beat, x lowest
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int a = 0; a < tama_pkg::AXES; a++) begin
        m_tdata[a*SW +: SW] <= lane_mean[a];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(WINDOW - 1))
    else $error("write slot beyond window");

  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(ptr))
    else $error("write slot moved without an accepted beat");

  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> ptr == $past(ptr_next))
    else $error("write slot missed its step");

  a_pipe_flow: assert property (@(posedge clk) disable iff (rst)
    (advance && sum_vld) |=> prod_vld)
    else $error("lane sum dropped before the divider");

  a_out_flow: assert property (@(posedge clk) disable iff (rst)
    (advance && prod_vld) |=> m_tvalid)
    else $error("divider result dropped before the output register");
`endif

endmodule

`default_nettype wire
